// File: sv/uiq4_pkg.sv
// Shared types and constants of the 4-bit quantizer and nibble packer.
`default_nettype none

package uiq4_pkg;

    // Field widths
    localparam int SAMPLE_W = 32;
    localparam int SCALE_W  = 32;
    localparam int DIM_W    = 13;
    localparam int CODE_W   = 4;
    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    // Default parameter values
    localparam int DEF_MAX_DIM   = 4096;
    localparam int DEF_PAD_BLOCK = 128;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [SCALE_W-1:0]         t_scale;
    typedef logic [DIM_W-1:0]           t_dim;
    typedef logic [CODE_W-1:0]          t_code;
    typedef logic [BYTE_W-1:0]          t_byte;
    typedef logic [CFG_W-1:0]           t_cfg_data;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;

    // Configuration register indexes
    localparam t_cfg_idx CFG_MINIMUM   = 2'd0;
    localparam t_cfg_idx CFG_SCALE     = 2'd1;
    localparam t_cfg_idx CFG_DIMENSION = 2'd2;

    // Configuration reset values
    localparam t_sample RST_MINIMUM   = 32'sd0;
    localparam t_scale  RST_SCALE     = 32'd16777216;
    localparam t_dim    RST_DIMENSION = 13'd1;

    // Rounding bias in Q24.40: one half minus 2^-25
    localparam logic [43:0] RND_BIAS = 44'h7F_FFFF_8000;
    localparam logic [23:0] CODE_SAT = 24'd15;
    localparam t_code       CODE_MAX = 4'd15;

endpackage

`default_nettype wire

// File: sv/uiq4_if.sv
// Valid/ready channel interfaces for sample input and packed byte output.
`default_nettype none

interface uiq4_in_if import uiq4_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface uiq4_out_if import uiq4_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte packed_byte;
    logic  row_end;
    logic  item_end;

    modport source (output valid, output packed_byte, output row_end, output item_end,
                    input ready);
    modport sink   (input valid, input packed_byte, input row_end, input item_end,
                    output ready);
endinterface

`default_nettype wire

// File: sv/uiq4_quant.sv
// Four-stage quantizer pipeline: subtract minimum, scale, clamp and round to a 4-bit code.
`default_nettype none

module uiq4_quant import uiq4_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_sample i_min,
    input  wire t_scale  i_scale,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_sample i_sample,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_code        o_code
);

    logic        r_v1, r_v2, r_v3, r_v4;
    t_sample     r_sample;
    logic        r_pos2, r_pos3;
    logic [31:0] r_mag;
    logic [63:0] r_prod;
    t_code       r_code;

    logic        s1_rdy, s2_rdy, s3_rdy, s4_rdy;
    logic [32:0] diff;
    logic        diff_pos;
    logic [63:0] prod;
    logic [43:0] rsum;
    t_code       code;

    // Stall chain: a stage loads when it is empty or its content moves on
    assign s4_rdy  = !r_v4 || i_ready;
    assign s3_rdy  = !r_v3 || s4_rdy;
    assign s2_rdy  = !r_v2 || s3_rdy;
    assign s1_rdy  = !r_v1 || s2_rdy;
    assign o_ready = s1_rdy;

    // Difference to minimum, exact in 33 bits
    always_comb begin
        diff     = {r_sample[SAMPLE_W-1], r_sample} - {i_min[SAMPLE_W-1], i_min};
        diff_pos = !diff[32] && (diff[31:0] != 32'd0);
    end

    // Scale product, Q24.40
    assign prod = 64'(r_mag) * 64'(i_scale);

    // Zero unless above minimum, else clamp at fifteen, add just under one half, truncate
    always_comb begin
        rsum = r_prod[43:0] + RND_BIAS;
        if (!r_pos3) begin
            code = '0;
        end else if (r_prod[63:40] >= CODE_SAT) begin
            code = CODE_MAX;
        end else begin
            code = rsum[43:40];
        end
    end

    // Advance stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (s1_rdy) r_v1 <= i_valid;
            if (s2_rdy) r_v2 <= r_v1;
            if (s3_rdy) r_v3 <= r_v2;
            if (s4_rdy) r_v4 <= r_v3;
        end
    end

    // Advance stage payloads
    always_ff @(posedge i_clk) begin
        if (s1_rdy && i_valid) begin
            r_sample <= i_sample;
        end
        if (s2_rdy && r_v1) begin
            r_pos2 <= diff_pos;
            r_mag  <= diff[31:0];
        end
        if (s3_rdy && r_v2) begin
            r_pos3 <= r_pos2;
            r_prod <= prod;
        end
        if (s4_rdy && r_v3) begin
            r_code <= code;
        end
    end

    assign o_valid = r_v4;
    assign o_code  = r_code;

endmodule

`default_nettype wire

// File: sv/uniform_int4_quantize_pack.sv
// A byte reaches the output once the sample that completes it has passed the quantizer
// stages and the output register. Throughput: one sample per cycle while the output accepts;
// at row end the padding bytes go out on the output register, and codes are held off during that burst.
// The pad length comes from the row byte count, derived from dimension through r_q and r_total.
// Reset (synchronous, active low): registers return to minimum 0, scale 1.0, dimension 1;
// row position and held nibble clear, pipeline and output empty.
`default_nettype none

module uniform_int4_quantize_pack import uiq4_pkg::*; #(
    parameter int MAX_DIM   = DEF_MAX_DIM,
    parameter int PAD_BLOCK = DEF_PAD_BLOCK
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire t_cfg_idx  i_cfg_idx,
    input  wire t_cfg_data i_cfg_data,
    uiq4_in_if.sink        i_in,
    uiq4_out_if.source     o_out
);

    // Derived sizes
    localparam int DIM_CAP = (MAX_DIM < 8191) ? MAX_DIM : 8191;
    localparam int IDX_W   = $clog2(DIM_CAP);
    localparam int CNT_W   = DIM_W + 1;
    localparam int PAD_W   = $clog2(PAD_BLOCK + 2);
    localparam int RCP_S   = CNT_W + $clog2(PAD_BLOCK);
    localparam int RCP_M   = ((1 << RCP_S) + PAD_BLOCK - 1) / PAD_BLOCK;
    localparam int RCP_PW  = CNT_W + 20;

    // Configuration registers
    t_sample r_min;
    t_scale  r_scale;
    t_dim    r_deff;
    t_dim    r_q;
    t_dim    r_total;

    // Row state
    logic [IDX_W-1:0] r_elem_idx;
    t_code            r_held;
    logic             r_pad_busy;
    logic [PAD_W-1:0] r_pad_cnt;

    // Output register
    logic  r_out_valid;
    t_byte r_out_byte;
    logic  r_out_row_end;
    logic  r_out_item_end;

    logic  n_out_valid;
    t_byte n_out_byte;
    logic  n_out_row_end;
    logic  n_out_item_end;
    logic             n_load;
    logic [IDX_W-1:0] n_elem_idx;
    t_code            n_held;
    logic             n_pad_busy;
    logic [PAD_W-1:0] n_pad_cnt;

    logic              code_valid;
    logic              code_ready;
    t_code             code;
    t_dim              dim_wr;
    logic [CNT_W-1:0]  rcp_num;
    logic [RCP_PW-1:0] rcp_prod;
    logic [CNT_W-1:0]  tot_prod;
    logic [CNT_W-1:0]  idx_ext;
    logic [CNT_W-1:0]  used_sum;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  pads_full;
    logic              out_free;
    logic              even;
    logic              last;
    logic              pad_last;

    uiq4_quant u_quant (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_min    (r_min),
        .i_scale  (r_scale),
        .i_valid  (i_in.valid),
        .o_ready  (i_in.ready),
        .i_sample (i_in.sample),
        .o_valid  (code_valid),
        .i_ready  (code_ready),
        .o_code   (code)
    );

    // Clamp written dimension to 1..cap
    always_comb begin
        dim_wr = i_cfg_data[DIM_W-1:0];
        if (dim_wr == '0) begin
            dim_wr = t_dim'(1);
        end else if (dim_wr > t_dim'(DIM_CAP)) begin
            dim_wr = t_dim'(DIM_CAP);
        end
    end

    // Row byte count: ceil(dim / PAD_BLOCK) * PAD_BLOCK / 2, by reciprocal multiply
    assign rcp_num  = CNT_W'(r_deff) + CNT_W'(PAD_BLOCK - 1);
    assign rcp_prod = RCP_PW'(rcp_num) * RCP_PW'(RCP_M);
    assign tot_prod = CNT_W'(r_q) * CNT_W'(PAD_BLOCK);

    // Hold configuration and derived counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= RST_MINIMUM;
            r_scale <= RST_SCALE;
            r_deff  <= RST_DIMENSION;
            r_q     <= t_dim'(1);
            r_total <= t_dim'(PAD_BLOCK / 2);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MINIMUM:   r_min   <= i_cfg_data;
                    CFG_SCALE:     r_scale <= i_cfg_data;
                    CFG_DIMENSION: r_deff  <= dim_wr;
                    default: ;
                endcase
            end
            r_q     <= rcp_prod[RCP_S +: DIM_W];
            r_total <= tot_prod[CNT_W-1:1];
        end
    end

    // Row position, pad count and whether the code can be taken now
    always_comb begin
        out_free   = !r_out_valid || o_out.ready;
        even       = !r_elem_idx[0];
        idx_ext    = CNT_W'(r_elem_idx);
        last       = (idx_ext + CNT_W'(1)) >= CNT_W'(r_deff);
        used_sum   = idx_ext + CNT_W'(2);
        used       = used_sum >> 1;
        pads_full  = (CNT_W'(r_total) > used) ? (CNT_W'(r_total) - used) : '0;
        pad_last   = (r_pad_cnt == PAD_W'(1));
        code_ready = !r_pad_busy && (out_free || (even && !last));
    end

    // Build next output and row state
    always_comb begin
        n_out_valid    = r_out_valid && !o_out.ready;
        n_out_byte     = r_out_byte;
        n_out_row_end  = r_out_row_end;
        n_out_item_end = r_out_item_end;
        n_load         = 1'b0;
        n_elem_idx     = r_elem_idx;
        n_held         = r_held;
        n_pad_busy     = r_pad_busy;
        n_pad_cnt      = r_pad_cnt;
        if (r_pad_busy) begin
            if (out_free) begin
                n_load         = 1'b1;
                n_out_valid    = 1'b1;
                n_out_byte     = '0;
                n_out_row_end  = pad_last;
                n_out_item_end = pad_last;
                n_pad_cnt      = r_pad_cnt - PAD_W'(1);
                n_pad_busy     = !pad_last;
            end
        end else if (code_valid && code_ready) begin
            if (even) begin
                n_held = code;
            end
            if (!even || last) begin
                n_load         = 1'b1;
                n_out_valid    = 1'b1;
                n_out_byte     = even ? {4'b0000, code} : {code, r_held};
                n_out_row_end  = last && (pads_full == '0);
                n_out_item_end = !last || (pads_full == '0);
            end
            if (last) begin
                n_elem_idx = '0;
                n_pad_busy = (pads_full != '0);
                n_pad_cnt  = pads_full[PAD_W-1:0];
            end else begin
                n_elem_idx = r_elem_idx + IDX_W'(1);
            end
        end
    end

    // Update control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_elem_idx  <= '0;
            r_held      <= '0;
            r_pad_busy  <= 1'b0;
            r_pad_cnt   <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_elem_idx  <= n_elem_idx;
            r_held      <= n_held;
            r_pad_busy  <= n_pad_busy;
            r_pad_cnt   <= n_pad_cnt;
        end
    end

    // Load output payload
    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_out_byte     <= n_out_byte;
            r_out_row_end  <= n_out_row_end;
            r_out_item_end <= n_out_item_end;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.packed_byte = r_out_byte;
    assign o_out.row_end     = r_out_row_end;
    assign o_out.item_end    = r_out_item_end;

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking testbench for the 4-bit quantizer and nibble packer.
module testbench;
    import uiq4_pkg::*;

    localparam int LIMIT_DIM     = 4096;
    localparam int PAD_LEN       = 128;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int LONG_HOLD     = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 280;
    localparam int BIG_ROW       = 64;
    localparam int PLAN_LEN      = 39;

    // Register index that the block ignores
    localparam t_cfg_idx CFG_SPARE = 2'd3;

    // Saturation point and rounding bias of the product, Q24.40
    localparam logic [63:0] CODE_CEIL = 64'd15 << 40;
    localparam logic [63:0] HALF_LESS = (64'd1 << 39) - (64'd1 << 15);

    typedef enum logic {STEP_SAMPLE, STEP_WRITE} t_plan_kind;

    typedef struct packed {
        t_plan_kind  kind;
        t_cfg_idx    reg_idx;
        logic [31:0] value;
        logic        fixed;
        t_byte       fixed_byte;
    } t_plan_step;

    typedef struct packed {
        t_byte packed_byte;
        logic  row_end;
        logic  item_end;
    } t_byte_result;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_cfg_we;
    t_cfg_idx  i_cfg_idx;
    t_cfg_data i_cfg_data;

    uiq4_in_if  in_ch ();
    uiq4_out_if out_ch ();

    uniform_int4_quantize_pack u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Shadow copy of the registers and the row state
    t_sample     shadow_min   = RST_MINIMUM;
    t_scale      shadow_scale = RST_SCALE;
    t_dim        shadow_dim   = RST_DIMENSION;
    int          row_pos      = 0;
    t_code       low_nibble   = '0;
    logic [31:0] span         = 32'h0010_0000;

    t_byte_result pending_bytes [$];

    int   mismatches   = 0;
    int   idle_cycles  = 0;
    int   in_idle_pct  = 20;
    int   out_idle_pct = 20;
    logic quiet        = 1'b0;
    logic hold_out     = 1'b0;

    always #2 i_clk = ~i_clk;

    // Effective row length after the zero and ceiling rules
    function automatic int row_len();
        int d;
        d = int'(shadow_dim);
        if (d == 0) d = 1;
        if (d > LIMIT_DIM) d = LIMIT_DIM;
        return d;
    endfunction

    function automatic t_code quantize_code(t_sample s);
        longint      diff;
        logic [63:0] prod;
        diff = longint'(s) - longint'(shadow_min);
        if (diff <= 0) return '0;
        prod = 64'(diff) * 64'(shadow_scale);
        if (prod >= CODE_CEIL) return CODE_MAX;
        prod = (prod + HALF_LESS) >> 40;
        return prod[3:0];
    endfunction

    // Compute the bytes one sample causes and queue them
    task automatic pack_sample(input t_sample s, input logic fixed, input t_byte fixed_byte);
        int           d, used, total, pads, count;
        logic         last, has_data;
        t_code        code;
        t_byte        data_byte;
        t_byte_result r;
        d        = row_len();
        code     = quantize_code(s);
        last     = (row_pos + 1 >= d);
        has_data = 1'b1;
        if (row_pos % 2 == 0) begin
            low_nibble = code;
            has_data   = last;
            data_byte  = {4'h0, code};
        end else begin
            data_byte = {code, low_nibble};
        end
        if (fixed) data_byte = fixed_byte;
        pads = 0;
        if (last) begin
            used    = (row_pos + 2) / 2;
            total   = (d + PAD_LEN - 1) / PAD_LEN * PAD_LEN / 2;
            pads    = (total > used) ? total - used : 0;
            row_pos = 0;
        end else begin
            row_pos = row_pos + 1;
        end
        count = pads + (has_data ? 1 : 0);
        for (int k = 0; k < count; k++) begin
            r.packed_byte = (k == 0 && has_data) ? data_byte : 8'h00;
            r.row_end     = last && (k == count - 1);
            r.item_end    = (k == count - 1);
            pending_bytes.push_back(r);
        end
    endtask

    // Offer one sample, with an optional idle burst ahead of it
    task automatic push_sample(input t_sample s, input logic fixed, input t_byte fixed_byte);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 99) < in_idle_pct) gap = $urandom_range(1, 5);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.sample <= s;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        pack_sample(s, fixed, fixed_byte);
    endtask

    // Stop offering, wait out every queued byte, then let the pipeline settle
    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MINIMUM:   shadow_min   = data;
            CFG_SCALE:     shadow_scale = data;
            CFG_DIMENSION: shadow_dim   = data[DIM_W-1:0];
            default: ;
        endcase
    endtask

    // Mostly samples inside or just above the interval, some below it, some anywhere
    function automatic t_sample draw_sample();
        t_sample s;
        case ($urandom_range(0, 9))
            0, 1:    s = $urandom;
            2:       s = shadow_min - t_sample'($urandom_range(0, span / 8));
            default: s = shadow_min + t_sample'($urandom_range(0, span + span / 8));
        endcase
        return s;
    endfunction

    function automatic int pick_rate();
        int pct;
        case ($urandom_range(0, 3))
            0:       pct = 0;
            1:       pct = 10;
            2:       pct = 30;
            default: pct = 60;
        endcase
        return pct;
    endfunction

    task automatic set_random_config();
        logic [31:0] r;
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 19))
                0:       write_reg(CFG_DIMENSION, 0);
                1, 2:    write_reg(CFG_DIMENSION, $urandom_range(126, 130));
                3, 4, 5: write_reg(CFG_DIMENSION, $urandom_range(10, 40));
                default: write_reg(CFG_DIMENSION, $urandom_range(1, 9));
            endcase
        end
        if ($urandom_range(0, 1) != 0) begin
            case ($urandom_range(0, 9))
                0:       write_reg(CFG_MINIMUM, 32'h8000_0000);
                1:       write_reg(CFG_MINIMUM, 32'h7FFF_FFFF);
                2, 3:    write_reg(CFG_MINIMUM, $urandom);
                default: write_reg(CFG_MINIMUM, $urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
            endcase
        end
        if ($urandom_range(0, 1) != 0) begin
            case ($urandom_range(0, 9))
                0:       write_reg(CFG_SCALE, 32'h0000_0000);
                1:       write_reg(CFG_SCALE, 32'hFFFF_FFFF);
                2, 3:    write_reg(CFG_SCALE, $urandom);
                default: begin
                    // Scale as fifteen over a random range
                    r    = $urandom_range(32'h0000_4000, 32'h0040_0000);
                    span = r;
                    write_reg(CFG_SCALE, t_cfg_data'(CODE_CEIL / r));
                end
            endcase
        end
        if ($urandom_range(0, 15) == 0) write_reg(CFG_SPARE, $urandom);
    endtask

    // Compare each output transaction with the oldest queued byte
    always @(posedge i_clk) begin : result_check
        t_byte_result want;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected byte, expected none, got %h row_end %b item_end %b",
                         $time, out_ch.packed_byte, out_ch.row_end, out_ch.item_end);
                mismatches++;
            end else begin
                want = pending_bytes.pop_front();
                if (out_ch.packed_byte !== want.packed_byte) begin
                    $display("%0t: packed_byte expected %h got %h",
                             $time, want.packed_byte, out_ch.packed_byte);
                    mismatches++;
                end
                if (out_ch.row_end !== want.row_end) begin
                    $display("%0t: row_end expected %b got %b",
                             $time, want.row_end, out_ch.row_end);
                    mismatches++;
                end
                if (out_ch.item_end !== want.item_end) begin
                    $display("%0t: item_end expected %b got %b",
                             $time, want.item_end, out_ch.item_end);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("** uniform_int4_quantize_pack: FAILED **");
            $finish;
        end
    end

    // Pace the output side: random bursts of back-pressure, one long hold on request
    initial begin : sink_pacing
        int gap;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_out) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_out = 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < out_idle_pct) begin
                gap = $urandom_range(1, 5);
                out_ch.ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        t_plan_step plan [PLAN_LEN];
        int         phase_no, random_items, d, n;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_MINIMUM;
        i_cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.sample = '0;

        // Directed steps; rows with a typed byte hold the first data byte of that sample
        plan = '{
            // reset values: dimension 1, scale 1.0, minimum 0
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h0000_0000, 1'b1, 8'h00},
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h0001_0000, 1'b1, 8'h01},
            // one half rounds down, one LSB above rounds up
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h0000_8000, 1'b1, 8'h00},
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h0000_8001, 1'b1, 8'h01},
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h7FFF_FFFF, 1'b1, 8'h0F},
            // zero dimension acts as one
            '{STEP_WRITE,  CFG_DIMENSION, 32'h0000_0000, 1'b0, 8'h00},
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h0003_0000, 1'b1, 8'h03},
            // zero scale gives code zero
            '{STEP_WRITE,  CFG_SCALE,     32'h0000_0000, 1'b0, 8'h00},
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h7FFF_FFFF, 1'b1, 8'h00},
            // widest difference and largest scale
            '{STEP_WRITE,  CFG_MINIMUM,   32'h8000_0000, 1'b0, 8'h00},
            '{STEP_WRITE,  CFG_SCALE,     32'hFFFF_FFFF, 1'b0, 8'h00},
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h7FFF_FFFF, 1'b1, 8'h0F},
            '{STEP_WRITE,  CFG_MINIMUM,   32'h7FFF_FFFF, 1'b0, 8'h00},
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h8000_0000, 1'b1, 8'h00},
            // one pair per row
            '{STEP_WRITE,  CFG_MINIMUM,   32'h0000_0000, 1'b0, 8'h00},
            '{STEP_WRITE,  CFG_SCALE,     32'h0100_0000, 1'b0, 8'h00},
            '{STEP_WRITE,  CFG_DIMENSION, 32'h0000_0002, 1'b0, 8'h00},
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h0002_0000, 1'b0, 8'h00},
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h0005_0000, 1'b1, 8'h52},
            // index outside the register list
            '{STEP_WRITE,  CFG_SPARE,     32'hFFFF_FFFF, 1'b0, 8'h00},
            // odd row length leaves an unpaired nibble
            '{STEP_WRITE,  CFG_DIMENSION, 32'h0000_0003, 1'b0, 8'h00},
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h0001_4000, 1'b0, 8'h00},
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h000A_C000, 1'b0, 8'h00},
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h000E_0000, 1'b0, 8'h00},
            // shrink the row under an odd position
            '{STEP_WRITE,  CFG_DIMENSION, 32'h0000_000A, 1'b0, 8'h00},
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h0004_0000, 1'b0, 8'h00},
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h0007_8000, 1'b0, 8'h00},
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h0000_0000, 1'b0, 8'h00},
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h000F_FFFF, 1'b0, 8'h00},
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h0009_0000, 1'b0, 8'h00},
            '{STEP_WRITE,  CFG_DIMENSION, 32'h0000_0003, 1'b0, 8'h00},
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h000C_0000, 1'b1, 8'hC9},
            // shrink the row under an even position
            '{STEP_WRITE,  CFG_DIMENSION, 32'h0000_000A, 1'b0, 8'h00},
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h0001_0000, 1'b0, 8'h00},
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h0002_0000, 1'b0, 8'h00},
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h0003_0000, 1'b0, 8'h00},
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h0004_0000, 1'b0, 8'h00},
            '{STEP_WRITE,  CFG_DIMENSION, 32'h0000_0002, 1'b0, 8'h00},
            '{STEP_SAMPLE, CFG_MINIMUM,   32'h0006_0000, 1'b1, 8'h06}
        };

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (plan[i]) begin
            if (plan[i].kind == STEP_WRITE) begin
                drain_results();
                write_reg(plan[i].reg_idx, plan[i].value);
            end else begin
                push_sample(plan[i].value, plan[i].fixed, plan[i].fixed_byte);
            end
        end

        // Random phases; the fourth one holds the output off for a long stretch
        phase_no     = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS || phase_no < 4) begin
            drain_results();
            in_idle_pct  = pick_rate();
            out_idle_pct = pick_rate();
            set_random_config();
            d = row_len();
            if (phase_no == 3)
                n = 40;
            else if ($urandom_range(0, 2) == 0)
                n = $urandom_range(1, d + 3);
            else
                n = d * ((d > 40) ? 1 : $urandom_range(1, 3));
            for (int k = 0; k < n; k++) begin
                push_sample(draw_sample(), 1'b0, 8'h00);
                if (phase_no == 3 && k == 0) hold_out = 1'b1;
            end
            random_items += n;
            phase_no++;
        end

        // Back-to-back samples without idling under the widest dimension value,
        // then a short row that ends the long one and pads it out
        drain_results();
        quiet = 1'b1;
        write_reg(CFG_DIMENSION, 32'h0000_1FFF);
        repeat (BIG_ROW) push_sample(draw_sample(), 1'b0, 8'h00);
        drain_results();
        write_reg(CFG_DIMENSION, 32'h0000_0002);
        push_sample(draw_sample(), 1'b0, 8'h00);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_bytes.size() == 0)
            $display("** uniform_int4_quantize_pack: PASSED **");
        else
            $display("** uniform_int4_quantize_pack: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
sv/uiq4_pkg.sv
sv/uiq4_if.sv
sv/uiq4_quant.sv
sv/uniform_int4_quantize_pack.sv
bench/testbench.sv
